/* sv/aes128_pkg.sv */
// Package with the AES-128 tables, control types and round functions.
`timescale 1ns / 1ps

package aes128_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_MODE     = 2'd2
  } cfg_reg_t;

  localparam int unsigned NumRounds = 10;

  // Control that travels with each block down the row of cells.
  typedef struct packed {
    logic vld;
    logic dec;
  } cell_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] DEC_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Round constant for key expansion step idx (1 to 10).
  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] rc;
    case (idx)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // RotWord, SubWord and the round constant applied to the last key word.
  function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ key_core(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // Undoes one expansion step: rc is the constant that produced k.
  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ key_core(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = inv ? DEC_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return o;
  endfunction

  // Byte r + 4c is row r of column c.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*src) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] c2 [4];
    logic [7:0] c3 [4];
    logic [7:0] c9 [4];
    logic [7:0] cb [4];
    logic [7:0] cd [4];
    logic [7:0] ce [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        m1[k] = s[127-8*(4*c+k) -: 8];
        m2[k] = xt(m1[k]);
        m4[k] = xt(m2[k]);
        m8[k] = xt(m4[k]);
        c2[k] = m2[k];
        c3[k] = m2[k] ^ m1[k];
        c9[k] = m8[k] ^ m1[k];
        cb[k] = m8[k] ^ m2[k] ^ m1[k];
        cd[k] = m8[k] ^ m4[k] ^ m1[k];
        ce[k] = m8[k] ^ m4[k] ^ m2[k];
      end
      if (inv) begin
        a0 = ce[0] ^ cb[1] ^ cd[2] ^ c9[3];
        a1 = c9[0] ^ ce[1] ^ cb[2] ^ cd[3];
        a2 = cd[0] ^ c9[1] ^ ce[2] ^ cb[3];
        a3 = cb[0] ^ cd[1] ^ c9[2] ^ ce[3];
      end else begin
        a0 = c2[0] ^ c3[1] ^ m1[2] ^ m1[3];
        a1 = m1[0] ^ c2[1] ^ c3[2] ^ m1[3];
        a2 = m1[0] ^ m1[1] ^ c2[2] ^ c3[3];
        a3 = c3[0] ^ m1[1] ^ m1[2] ^ c2[3];
      end
      o[127-32*c -: 32] = {a0, a1, a2, a3};
    end
    return o;
  endfunction

endpackage

/* sv/aes128_block_cipher_unit.sv */
// Top level of the AES-128 ECB cipher: configuration, key expander and row of round cells.
`timescale 1ns / 1ps

// AES-128 (FIPS-197) block cipher in ECB form, encrypt or decrypt by cfg
// register REG_MODE. A request is one 128-bit block; the result passes the
// key-addition register, loaded at the accepting edge, and then the ten
// registered round cells, and with no output stall and no key expansion
// running one request is accepted every cycle.
// Each round cell derives its round key from the one handed over by the
// previous cell, so the key travels with the block. Decryption starts from
// the last round key, which a sequential expander computes after each
// write of key_high or key_low; in_stall stays high while it runs. All
// cells advance together, so an output stall on a valid result holds the
// whole row and raises in_stall as well.
module aes128_block_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);

  localparam int unsigned NR = aes128_pkg::NumRounds;

  logic [63:0] key_high_r, key_low_r;
  logic        mode_r;

  // Last-round-key expander.
  logic         exp_busy_r;
  logic [3:0]   exp_cnt_r;
  logic [127:0] exp_key_r;
  logic [127:0] new_key;
  logic         key_write;

  logic en;
  logic in_accept;

  // Entry stage registers.
  aes128_pkg::cell_ctl_t ctl0_r;
  logic [127:0]          st0_r;
  logic [127:0]          rk0_r;

  aes128_pkg::cell_ctl_t ctl [NR+1];
  logic [127:0] st [NR+1];
  logic [127:0] rk [NR+1];

  assign key_write = cfg_we && (cfg_index == aes128_pkg::REG_KEY_HIGH ||
                                cfg_index == aes128_pkg::REG_KEY_LOW);

  always_comb begin
    new_key = {key_high_r, key_low_r};
    if (cfg_index == aes128_pkg::REG_KEY_HIGH) begin
      new_key[127:64] = cfg_wdata;
    end else begin
      new_key[63:0] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      mode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        aes128_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata;
        aes128_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        aes128_pkg::REG_MODE:     mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Ten forward key steps turn the cipher key into the last round key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_busy_r <= 1'b0;
      exp_cnt_r  <= '0;
    end else if (key_write) begin
      exp_busy_r <= 1'b1;
      exp_cnt_r  <= '0;
    end else if (exp_busy_r) begin
      exp_cnt_r <= exp_cnt_r + 4'd1;
      if (exp_cnt_r == 4'(NR - 1)) begin
        exp_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_write) begin
      exp_key_r <= new_key;
    end else if (exp_busy_r) begin
      exp_key_r <= aes128_pkg::key_fwd(exp_key_r, aes128_pkg::rcon(exp_cnt_r + 4'd1));
    end
  end

  // The whole row moves when the output register is free or being taken.
  assign en        = !ctl[NR].vld || !out_stall;
  assign in_stall  = exp_busy_r || !en;
  assign in_accept = in_valid && !in_stall;

  // Entry stage: initial key addition with the first key of the chosen direction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r.vld <= in_accept;
      ctl0_r.dec <= mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rk0_r <= mode_r ? exp_key_r : {key_high_r, key_low_r};
      st0_r <= {in_block_high, in_block_low} ^
               (mode_r ? exp_key_r : {key_high_r, key_low_r});
    end
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;
  assign rk[0]  = rk0_r;

  for (genvar g = 1; g <= NR; g++) begin : g_cell
    aes128_cell #(
      .ROUND(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl[g-1]),
      .state_i(st[g-1]),
      .key_i  (rk[g-1]),
      .ctl_o  (ctl[g]),
      .state_o(st[g]),
      .key_o  (rk[g])
    );
  end

  assign out_valid       = ctl[NR].vld;
  assign out_result_high = st[NR][127:64];
  assign out_result_low  = st[NR][63:0];

endmodule

/* sv/aes128_cell.sv */
// One round cell: a cipher round (without MixColumns in the last) plus one round key step, registered.
`timescale 1ns / 1ps

module aes128_cell #(
  parameter int unsigned ROUND = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  aes128_pkg::cell_ctl_t ctl_i,
  input  logic [127:0]          state_i,
  input  logic [127:0]          key_i,
  output aes128_pkg::cell_ctl_t ctl_o,
  output logic [127:0]          state_o,
  output logic [127:0]          key_o
);

  // Encryption walks keys forward, decryption walks them back from the last one.
  localparam logic [7:0] RcEnc = aes128_pkg::rcon(4'(ROUND));
  localparam logic [7:0] RcDec = aes128_pkg::rcon(4'(aes128_pkg::NumRounds + 1 - ROUND));
  localparam bit IsLast = (ROUND == aes128_pkg::NumRounds);

  aes128_pkg::cell_ctl_t ctl_r;
  logic [127:0] state_r, state_nxt;
  logic [127:0] key_r, key_nxt;
  logic [127:0] sub_shift;

  always_comb begin
    key_nxt = ctl_i.dec ? aes128_pkg::key_inv(key_i, RcDec)
                        : aes128_pkg::key_fwd(key_i, RcEnc);
    // SubBytes and ShiftRows commute, so both directions share this order.
    sub_shift = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(state_i, ctl_i.dec), ctl_i.dec);
    if (IsLast) begin
      state_nxt = sub_shift ^ key_nxt;
    end else if (ctl_i.dec) begin
      state_nxt = aes128_pkg::mix_columns(sub_shift ^ key_nxt, 1'b1);
    end else begin
      state_nxt = aes128_pkg::mix_columns(sub_shift, 1'b0) ^ key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign state_o = state_r;
  assign key_o   = key_r;

endmodule

/* sv/aes128_checker.sv */
// Port-level checker for the AES-128 cipher unit and its bind.
`timescale 1ns / 1ps

module aes128_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_high,
  input logic [63:0] out_result_low
);

  // A held result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_high) &&
                               $stable(out_result_low))
    else $error("stalled result changed");

  // The key expander blocks requests right after a key write.
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == aes128_pkg::REG_KEY_HIGH ||
               cfg_index == aes128_pkg::REG_KEY_LOW) |=> in_stall)
    else $error("request possible during key expansion");

  // A blocked output also blocks the input side.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind aes128_block_cipher_unit aes128_checker u_aes128_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_result_high(out_result_high),
  .out_result_low (out_result_low)
);

/* dv/aes128_block_cipher_unit_tb.sv */
// Self-checking testbench for the AES-128 ECB block cipher unit.
`timescale 1ns / 1ps

module aes128_block_cipher_unit_tb;

  // This index lies beyond the register list, so a write to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Pipeline depth is eleven stages, and the key expander must also finish its run.
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;

  aes128_block_cipher_unit dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_block_high, .in_block_low,
    .out_valid, .out_stall, .out_result_high, .out_result_low
  );

  // Our own copy of the cipher state: substitution tables, key registers,
  // expanded schedule and the direction bit.
  logic [7:0]   sub_fwd [256];
  logic [7:0]   sub_inv [256];
  logic [63:0]  key_hi_q;
  logic [63:0]  key_lo_q;
  logic         decrypt_q;
  logic [127:0] sched [11];

  block_t pending_blocks[$];
  block_t expected_results[$];

  int unsigned issued;
  int unsigned accepted;
  int unsigned cycles;
  int unsigned errors;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          no_idle;

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_double(a);
    end
    return r;
  endfunction

  // The S-box is built from the field inverse followed by the affine map.
  task automatic build_sboxes();
    logic [7:0] inv_x;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv_x = 8'h00;
      if (x != 0) begin
        inv_x = 8'h01;
        for (int k = 0; k < 254; k++) inv_x = gf_mul(inv_x, x[7:0]);
      end
      s = inv_x ^ {inv_x[6:0], inv_x[7]} ^ {inv_x[5:0], inv_x[7:6]}
          ^ {inv_x[4:0], inv_x[7:5]} ^ {inv_x[3:0], inv_x[7:4]} ^ 8'h63;
      sub_fwd[x] = s;
      sub_inv[s] = x[7:0];
    end
  endtask

  task automatic expand_schedule();
    logic [7:0] w [176];
    logic [7:0] rc;
    logic [7:0] t0, t1, t2, t3, h;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i]     = key_hi_q[63-8*i -: 8];
      w[8 + i] = key_lo_q[63-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      t0 = w[i-4]; t1 = w[i-3]; t2 = w[i-2]; t3 = w[i-1];
      if (i % 16 == 0) begin
        h  = t0;
        t0 = sub_fwd[t1] ^ rc;
        t1 = sub_fwd[t2];
        t2 = sub_fwd[t3];
        t3 = sub_fwd[h];
        rc = gf_double(rc);
      end
      w[i]   = w[i-16] ^ t0;
      w[i+1] = w[i-15] ^ t1;
      w[i+2] = w[i-14] ^ t2;
      w[i+3] = w[i-13] ^ t3;
    end
    for (int r = 0; r < 11; r++)
      for (int b = 0; b < 16; b++) sched[r][127-8*b -: 8] = w[16*r + b];
  endtask

  // Works out the ciphered block for the current key and direction.
  // State byte r + 4c holds row r of column c; byte 0 is the top byte.
  function automatic block_t cipher_block(block_t blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [4];
    logic [7:0] v;
    block_t res;
    int rnd, src;
    for (int i = 0; i < 8; i++) begin
      s[i]     = blk.hi[63-8*i -: 8];
      s[8 + i] = blk.lo[63-8*i -: 8];
    end
    for (int step = 0; step <= 10; step++) begin
      rnd = decrypt_q ? 10 - step : step;
      // The inverse cipher applies its steps in reverse, mixing after the key.
      if (step > 0) begin
        for (int i = 0; i < 16; i++) s[i] = decrypt_q ? s[i] : sub_fwd[s[i]];
        t = s;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = decrypt_q ? (c + 4 - r) % 4 : (c + r) % 4;
            s[r + 4*c] = t[r + 4*src];
          end
        if (decrypt_q)
          for (int i = 0; i < 16; i++) s[i] = sub_inv[s[i]];
        if (!decrypt_q && step < 10) begin
          t = s;
          m = '{8'd2, 8'd3, 8'd1, 8'd1};
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
              v = 8'h00;
              for (int k = 0; k < 4; k++) v ^= gf_mul(m[(k + 4 - r) % 4], t[4*c + k]);
              s[4*c + r] = v;
            end
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= sched[rnd][127-8*i -: 8];
      if (decrypt_q && step > 0 && step < 10) begin
        t = s;
        m = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gf_mul(m[(k + 4 - r) % 4], t[4*c + k]);
            s[4*c + r] = v;
          end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8 + i];
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: every accepted request gets its expectation at the same edge, and
  // every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    block_t blk;
    block_t exp_res;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        blk.hi = in_block_high;
        blk.lo = in_block_low;
        expected_results.push_back(cipher_block(blk));
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h %h", out_result_high, out_result_low);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_result_high !== exp_res.hi) begin
            $error("result_high: expected %h, got %h", exp_res.hi, out_result_high);
            errors++;
          end
          if (out_result_low !== exp_res.lo) begin
            $error("result_low: expected %h, got %h", exp_res.lo, out_result_low);
            errors++;
          end
        end
      end
    end
  end

  // Request driver. A held request stays put until it is accepted; idle gaps
  // are chosen without looking at in_stall.
  always @(negedge clk) begin
    logic   nxt_valid;
    block_t blk;
    nxt_valid = in_valid;
    if (rst_n && (!in_valid || accepted == issued)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 18);
      end else if (pending_blocks.size() > 0) begin
        blk = pending_blocks.pop_front();
        in_block_high <= blk.hi;
        in_block_low  <= blk.lo;
        issued++;
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
  end

  // Result-side back-pressure in random bursts.
  always @(negedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (out_gap > 0) begin
      out_gap--;
      nxt_stall = 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 18);
      nxt_stall = 1'b1;
    end
    out_stall <= nxt_stall;
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aes128_pkg::REG_KEY_HIGH: begin
        key_hi_q = value;
        expand_schedule();
      end
      aes128_pkg::REG_KEY_LOW: begin
        key_lo_q = value;
        expand_schedule();
      end
      aes128_pkg::REG_MODE: decrypt_q = value[0];
      default:              ;
    endcase
  endtask

  // The sender holds off until every request has been answered and the row
  // has drained, so register writes always land on an idle block.
  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_block(logic [63:0] hi, logic [63:0] lo);
    block_t blk;
    blk.hi = hi;
    blk.lo = lo;
    pending_blocks.push_back(blk);
  endtask

  task automatic queue_directed();
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    queue_block(64'h8000000000000000, 64'h0000000000000001);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) queue_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    logic [63:0] kh, kl;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = aes128_pkg::REG_KEY_HIGH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_block_high = '0;
    in_block_low = '0;
    out_stall = 1'b0;
    issued = 0;
    accepted = 0;
    cycles = 0;
    errors = 0;
    in_gap = 0;
    out_gap = 0;
    no_idle = 1'b0;
    key_hi_q = '0;
    key_lo_q = '0;
    decrypt_q = 1'b0;
    build_sboxes();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The standard test key, encrypting and then decrypting the same blocks.
    write_reg(aes128_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(aes128_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_reg(aes128_pkg::REG_MODE, 64'd0);
    queue_directed();
    wait_drained();
    // Only bit 0 of the mode write counts, and the unused index does nothing.
    write_reg(aes128_pkg::REG_MODE, 64'hffffffffffffffff);
    write_reg(REG_UNUSED, 64'hdeadbeefcafef00d);
    queue_directed();
    wait_drained();

    // Random phases over a spread of keys, the all-zero and all-one keys among them.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin kh = '0; kl = '0; end
        1: begin kh = '1; kl = '1; end
        default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
      endcase
      // Sometimes rewrite one half only, which must still trigger a fresh expansion.
      if (phase < 2 || $urandom_range(0, 2) != 0) write_reg(aes128_pkg::REG_KEY_HIGH, kh);
      write_reg(aes128_pkg::REG_KEY_LOW, kl);
      write_reg(aes128_pkg::REG_MODE,
                {$urandom, $urandom} & 64'hfffffffffffffffe | (phase % 2));
      no_idle = (phase == 7);
      queue_random(105);
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
